// ===== hdl/mpp_pkg.sv =====
// Package for the MQTT v5 property section parser.
// Holds the role, kind and error codes, the result record and the identifier decoder.
// No dependencies.
package mpp_pkg;

	localparam logic [2:0] ROLE_SECTION_LEN = 3'd0;
	localparam logic [2:0] ROLE_PROP_ID     = 3'd1;
	localparam logic [2:0] ROLE_LEN_PREFIX  = 3'd2;
	localparam logic [2:0] ROLE_VALUE       = 3'd3;
	localparam logic [2:0] ROLE_OUTSIDE     = 3'd4;

	localparam logic [2:0] K_BYTE    = 3'd0;
	localparam logic [2:0] K_TWO     = 3'd1;
	localparam logic [2:0] K_FOUR    = 3'd2;
	localparam logic [2:0] K_VARINT  = 3'd3;
	localparam logic [2:0] K_STRING  = 3'd4;
	localparam logic [2:0] K_BINARY  = 3'd5;
	localparam logic [2:0] K_PAIR    = 3'd6;
	localparam logic [2:0] K_UNKNOWN = 3'd7;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN = 2'd1;
	localparam logic [1:0] ERR_OVERRUN = 2'd2;

	typedef struct packed {
		logic [2:0]  byte_role;
		logic [7:0]  data_out;
		logic [7:0]  prop_id;
		logic [2:0]  prop_kind;
		logic [31:0] int_value;
		logic        prop_last;
		logic        section_last;
		logic [1:0]  error_code;
	} result_t;

	function automatic logic [2:0] kind_of(input logic [7:0] id);
		logic [2:0] k;
		unique case (id) inside
			8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A: k = K_BYTE;
			8'h13, 8'h21, 8'h22, 8'h23:                             k = K_TWO;
			8'h02, 8'h11, 8'h18, 8'h27:                             k = K_FOUR;
			8'h0B:                                                  k = K_VARINT;
			8'h03, 8'h08, 8'h12, 8'h15, 8'h1A, 8'h1C, 8'h1F:        k = K_STRING;
			8'h09, 8'h16:                                           k = K_BINARY;
			8'h26:                                                  k = K_PAIR;
			default:                                                k = K_UNKNOWN;
		endcase
		return k;
	endfunction

	// Seven-bit varint group placed at its position (group index 0..3).
	function automatic logic [27:0] varint_term(input logic [7:0] b, input logic [1:0] n);
		logic [27:0] t;
		case (n)
			2'd0:    t = {21'd0, b[6:0]};
			2'd1:    t = {14'd0, b[6:0], 7'd0};
			2'd2:    t = {7'd0, b[6:0], 14'd0};
			default: t = {b[6:0], 21'd0};
		endcase
		return t;
	endfunction

endpackage

// ===== hdl/mqtt5_property_section_parser_top.sv =====
// A request accepted at the input is held in the input register, then its result in the
// result register. Throughput: one byte per cycle while out_ready stays high; the single
// step from input register through the parser state to the result register sets the rate.
// Reset (arst_n low, asynchronous): both stages empty, parser outside any section, all
// counters and the accumulator cleared. No clearing pass follows reset.
// Depends on mpp_pkg and mpp_core.
module mqtt5_property_section_parser_top #(
	parameter int MAX_VARINT_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        section_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  byte_role,
	output logic [7:0]  data_out,
	output logic [7:0]  prop_id,
	output logic [2:0]  prop_kind,
	output logic [31:0] int_value,
	output logic        prop_last,
	output logic        section_last,
	output logic [1:0]  error_code
);
	import mpp_pkg::*;

	// Input stage: hold one request until the parser step can run on it.
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       start_s1;

	// Result stage: hold one finished result until the consumer takes it.
	logic    valid_s2;
	result_t res_s2;
	result_t step_res;

	// Advance the input stage whenever the result slot is free or being emptied.
	logic advance;
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_byte;
			start_s1 <= section_start;
		end
	end

	// Parser state advances exactly once per request, at the moment it moves to stage 2.
	mpp_core #(
		.MAX_VARINT_BYTES(MAX_VARINT_BYTES)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (advance),
		.data_byte    (data_s1),
		.section_start(start_s1),
		.result       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= step_res;
	end

	assign out_valid    = valid_s2;
	assign byte_role    = res_s2.byte_role;
	assign data_out     = res_s2.data_out;
	assign prop_id      = res_s2.prop_id;
	assign prop_kind    = res_s2.prop_kind;
	assign int_value    = res_s2.int_value;
	assign prop_last    = res_s2.prop_last;
	assign section_last = res_s2.section_last;
	assign error_code   = res_s2.error_code;

endmodule

// ===== hdl/mpp_core.sv =====
// Parser state and one-byte step logic for the MQTT v5 property section parser.
// Depends on mpp_pkg.
module mpp_core #(
	parameter int MAX_VARINT_BYTES = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step_en,
	input  logic [7:0]      data_byte,
	input  logic            section_start,
	output mpp_pkg::result_t result
);
	import mpp_pkg::*;

	localparam logic [2:0] PH_OUTSIDE   = 3'd0;
	localparam logic [2:0] PH_LENGTH    = 3'd1;
	localparam logic [2:0] PH_ID        = 3'd2;
	localparam logic [2:0] PH_PREFIX_HI = 3'd3;
	localparam logic [2:0] PH_PREFIX_LO = 3'd4;
	localparam logic [2:0] PH_VALUE     = 3'd5;
	localparam logic [2:0] PH_VARINT    = 3'd6;

	localparam logic [2:0] MaxVb = 3'(MAX_VARINT_BYTES);

	logic [2:0]  phase_q, phase_n, phase_w;
	logic [27:0] sec_q, sec_n, sec_w;
	logic [1:0]  cnt_q, cnt_n, cnt_w;
	logic [7:0]  id_q, id_n;
	logic [2:0]  kind_q, kind_n;
	logic [16:0] vrem_q, vrem_n;
	logic        pend_q, pend_n;
	logic [7:0]  hi_q, hi_n;
	logic [31:0] acc_q, acc_n;
	logic        varint_end, done;
	logic [27:0] term;
	logic [15:0] prefix_len;

	always_comb begin
		phase_w = phase_q;
		sec_w   = sec_q;
		cnt_w   = cnt_q;
		if (section_start) begin
			phase_w = PH_LENGTH;
			sec_w   = '0;
			cnt_w   = '0;
		end
		phase_n = phase_w;
		sec_n   = sec_w;
		cnt_n   = cnt_w;
		id_n    = id_q;
		kind_n  = kind_q;
		vrem_n  = vrem_q;
		pend_n  = pend_q;
		hi_n    = hi_q;
		acc_n   = acc_q;
		done    = 1'b0;
		term    = varint_term(data_byte, cnt_w);
		varint_end = !data_byte[7] || (({1'b0, cnt_w} + 3'd1) >= MaxVb);
		prefix_len = {hi_q, data_byte};

		result              = '0;
		result.byte_role    = ROLE_OUTSIDE;
		result.data_out     = data_byte;

		if (phase_w == PH_LENGTH) begin
			result.byte_role = ROLE_SECTION_LEN;
			sec_n = sec_w + term;
			cnt_n = cnt_w + 2'd1;
			if (varint_end) begin
				cnt_n = '0;
				if (sec_n == '0) begin
					result.section_last = 1'b1;
					phase_n = PH_OUTSIDE;
				end else begin
					phase_n = PH_ID;
				end
			end
		end else if (phase_w != PH_OUTSIDE && phase_w <= PH_VARINT) begin
			unique case (phase_w)
				PH_ID: begin
					result.byte_role = ROLE_PROP_ID;
					id_n   = data_byte;
					kind_n = kind_of(data_byte);
					acc_n  = '0;
					pend_n = 1'b0;
					case (kind_n) inside
						K_BYTE: begin vrem_n = 17'd1; phase_n = PH_VALUE; end
						K_TWO:  begin vrem_n = 17'd2; phase_n = PH_VALUE; end
						K_FOUR: begin vrem_n = 17'd4; phase_n = PH_VALUE; end
						K_VARINT: begin cnt_n = '0; phase_n = PH_VARINT; end
						K_STRING, K_BINARY: phase_n = PH_PREFIX_HI;
						K_PAIR: begin pend_n = 1'b1; phase_n = PH_PREFIX_HI; end
						default: begin
							result.error_code = ERR_UNKNOWN;
							done = 1'b1;
						end
					endcase
				end
				PH_PREFIX_HI: begin
					result.byte_role = ROLE_LEN_PREFIX;
					hi_n    = data_byte;
					phase_n = PH_PREFIX_LO;
				end
				PH_PREFIX_LO: begin
					result.byte_role = ROLE_LEN_PREFIX;
					if (prefix_len != '0) begin
						vrem_n  = {1'b0, prefix_len};
						phase_n = PH_VALUE;
					end else if (pend_q) begin
						pend_n  = 1'b0;
						phase_n = PH_PREFIX_HI;
					end else begin
						done = 1'b1;
					end
				end
				PH_VALUE: begin
					result.byte_role = ROLE_VALUE;
					acc_n  = {acc_q[23:0], data_byte};
					vrem_n = vrem_q - 17'd1;
					if (vrem_n == '0) begin
						if (kind_q == K_PAIR && pend_q) begin
							pend_n  = 1'b0;
							phase_n = PH_PREFIX_HI;
						end else begin
							done = 1'b1;
							if (kind_q <= K_FOUR)
								result.int_value = acc_n;
						end
					end
				end
				default: begin
					// property varint
					result.byte_role = ROLE_VALUE;
					acc_n = acc_q + {4'd0, term};
					cnt_n = cnt_w + 2'd1;
					if (varint_end) begin
						cnt_n = '0;
						done  = 1'b1;
						result.int_value = acc_n;
					end
				end
			endcase

			result.prop_id   = id_n;
			result.prop_kind = kind_n;
			sec_n = sec_w - 28'd1;

			if (done) begin
				result.prop_last = 1'b1;
				if (sec_n == '0) begin
					result.section_last = 1'b1;
					phase_n = PH_OUTSIDE;
				end else begin
					phase_n = PH_ID;
				end
			end else if (sec_n == '0) begin
				result.prop_last    = 1'b1;
				result.section_last = 1'b1;
				result.error_code   = ERR_OVERRUN;
				phase_n = PH_OUTSIDE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OUTSIDE;
			sec_q   <= '0;
			cnt_q   <= '0;
			id_q    <= '0;
			kind_q  <= '0;
			vrem_q  <= '0;
			pend_q  <= 1'b0;
			hi_q    <= '0;
			acc_q   <= '0;
		end else if (step_en) begin
			phase_q <= phase_n;
			sec_q   <= sec_n;
			cnt_q   <= cnt_n;
			id_q    <= id_n;
			kind_q  <= kind_n;
			vrem_q  <= vrem_n;
			pend_q  <= pend_n;
			hi_q    <= hi_n;
			acc_q   <= acc_n;
		end
	end

endmodule

// ===== hdl/mpp_checker.sv =====
// Port-level checks for the MQTT v5 property section parser, bound to the top level.
// Depends on mpp_pkg.
module mpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  byte_role,
	input logic [7:0]  prop_id,
	input logic [2:0]  prop_kind,
	input logic        prop_last,
	input logic        section_last,
	input logic [1:0]  error_code
);
	import mpp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_role) && $stable(error_code))
		else $error("result dropped or changed while stalled");

	a_slast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && section_last |-> prop_last || byte_role == ROLE_SECTION_LEN)
		else $error("section end without property end");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> prop_last)
		else $error("error flagged on a non-final byte");

	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_UNKNOWN |-> byte_role == ROLE_PROP_ID
			&& prop_kind == K_UNKNOWN)
		else $error("unknown id flag on wrong byte");

	a_untagged: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (byte_role == ROLE_OUTSIDE || byte_role == ROLE_SECTION_LEN)
			|-> prop_id == 8'd0 && prop_kind == K_BYTE)
		else $error("property tag on a byte outside any property");

endmodule

bind mqtt5_property_section_parser_top mpp_checker u_mpp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.byte_role   (byte_role),
	.prop_id     (prop_id),
	.prop_kind   (prop_kind),
	.prop_last   (prop_last),
	.section_last(section_last),
	.error_code  (error_code)
);

// ===== bench/mqtt5_property_section_parser_top_tb.sv =====
// Self-checking bench for the MQTT v5 property section parser: drives byte streams
// over the request channel, predicts every tag in a local parser model, compares results.
// Depends on mpp_pkg (codes, result_t) and mqtt5_property_section_parser_top.
module mqtt5_property_section_parser_top_tb;
	import mpp_pkg::*;

	localparam int VARINT_MAX   = 4;
	localparam int RANDOM_BYTES = 900;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_WAIT  = 8;
	localparam int REPORT_MAX   = 10;

	// Receiver stall modes
	localparam int RX_ALWAYS  = 0;
	localparam int RX_COIN    = 1;
	localparam int RX_SPARSE  = 2;
	localparam int RX_PATTERN = 3;

	typedef enum logic [2:0] {
		PH_OUTSIDE, PH_LENGTH, PH_ID, PH_PREFIX_HI, PH_PREFIX_LO, PH_VALUE, PH_VARINT
	} parse_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        section_start = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  byte_role;
	logic [7:0]  data_out;
	logic [7:0]  prop_id;
	logic [2:0]  prop_kind;
	logic [31:0] int_value;
	logic        prop_last;
	logic        section_last;
	logic [1:0]  error_code;

	// Local copy of the parser state, cleared the same way reset clears the block.
	parse_phase_t ph = PH_OUTSIDE;
	logic [27:0] sec_left = '0;
	logic [1:0]  vb_count = '0;
	logic [7:0]  cur_id = '0;
	logic [2:0]  cur_kind = '0;
	logic [16:0] val_left = '0;
	logic        pair_second = 1'b0;
	logic [7:0]  len_hi = '0;
	logic [31:0] acc = '0;

	result_t     tag_queue[$];
	logic [7:0]  section_body[$];

	bit driving = 1'b0;
	int burst_left = 0;
	int bytes_sent = 0;
	int results_checked = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int sections_opened = 0;
	int restarts = 0;
	int props_closed = 0;
	int unknown_seen = 0;
	int overruns_seen = 0;
	int stray_seen = 0;
	int rx_mode = RX_ALWAYS;
	int rx_left = 0;
	logic [7:0] rx_pattern = 8'b1011_0110;
	result_t got;
	result_t want;

	mqtt5_property_section_parser_top #(
		.MAX_VARINT_BYTES(VARINT_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.section_start(section_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.byte_role(byte_role),
		.data_out(data_out),
		.prop_id(prop_id),
		.prop_kind(prop_kind),
		.int_value(int_value),
		.prop_last(prop_last),
		.section_last(section_last),
		.error_code(error_code)
	);

	always #4 clk = ~clk;

	// Map a property identifier to the form of its value.
	function automatic logic [2:0] id_kind(input logic [7:0] id);
		case (id) inside
			8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A: return K_BYTE;
			8'h13, 8'h21, 8'h22, 8'h23: return K_TWO;
			8'h02, 8'h11, 8'h18, 8'h27: return K_FOUR;
			8'h0B: return K_VARINT;
			8'h03, 8'h08, 8'h12, 8'h15, 8'h1A, 8'h1C, 8'h1F: return K_STRING;
			8'h09, 8'h16: return K_BINARY;
			8'h26: return K_PAIR;
			default: return K_UNKNOWN;
		endcase
	endfunction

	// Advance the local parser by one byte and return the tag the block must produce.
	function automatic result_t tag_byte(input logic [7:0] b, input logic start);
		result_t r;
		logic done;
		int n;
		logic [15:0] plen;
		r = '0;
		r.byte_role = ROLE_OUTSIDE;
		r.data_out = b;
		done = 1'b0;
		if (start) begin
			ph = PH_LENGTH;
			sec_left = '0;
			vb_count = '0;
		end
		if (ph == PH_LENGTH) begin
			n = int'(vb_count);
			r.byte_role = ROLE_SECTION_LEN;
			sec_left = sec_left + (28'(b[6:0]) << (7 * n));
			vb_count = vb_count + 2'd1;
			// Stop on a clear continuation bit or on the last allowed group.
			if (!b[7] || n + 1 >= VARINT_MAX) begin
				vb_count = '0;
				if (sec_left == '0) begin
					r.section_last = 1'b1;
					ph = PH_OUTSIDE;
				end else begin
					ph = PH_ID;
				end
			end
		end else if (ph != PH_OUTSIDE) begin
			case (ph)
				PH_ID: begin
					r.byte_role = ROLE_PROP_ID;
					cur_id = b;
					cur_kind = id_kind(b);
					acc = '0;
					pair_second = 1'b0;
					case (cur_kind) inside
						K_BYTE: begin
							val_left = 17'd1;
							ph = PH_VALUE;
						end
						K_TWO: begin
							val_left = 17'd2;
							ph = PH_VALUE;
						end
						K_FOUR: begin
							val_left = 17'd4;
							ph = PH_VALUE;
						end
						K_VARINT: begin
							vb_count = '0;
							ph = PH_VARINT;
						end
						K_STRING, K_BINARY: ph = PH_PREFIX_HI;
						K_PAIR: begin
							pair_second = 1'b1;
							ph = PH_PREFIX_HI;
						end
						default: begin
							// Unknown identifier: the id byte alone closes the property.
							r.error_code = ERR_UNKNOWN;
							done = 1'b1;
						end
					endcase
				end
				PH_PREFIX_HI: begin
					r.byte_role = ROLE_LEN_PREFIX;
					len_hi = b;
					ph = PH_PREFIX_LO;
				end
				PH_PREFIX_LO: begin
					r.byte_role = ROLE_LEN_PREFIX;
					plen = {len_hi, b};
					if (plen != 16'd0) begin
						val_left = {1'b0, plen};
						ph = PH_VALUE;
					end else if (pair_second) begin
						// Empty first string of a pair: go straight to the second prefix.
						pair_second = 1'b0;
						ph = PH_PREFIX_HI;
					end else begin
						done = 1'b1;
					end
				end
				PH_VALUE: begin
					r.byte_role = ROLE_VALUE;
					acc = {acc[23:0], b};
					val_left = val_left - 17'd1;
					if (val_left == '0) begin
						if (cur_kind == K_PAIR && pair_second) begin
							pair_second = 1'b0;
							ph = PH_PREFIX_HI;
						end else begin
							done = 1'b1;
							if (cur_kind == K_BYTE || cur_kind == K_TWO || cur_kind == K_FOUR)
								r.int_value = acc;
						end
					end
				end
				default: begin
					n = int'(vb_count);
					r.byte_role = ROLE_VALUE;
					acc = acc + (32'(b[6:0]) << (7 * n));
					vb_count = vb_count + 2'd1;
					if (!b[7] || n + 1 >= VARINT_MAX) begin
						vb_count = '0;
						done = 1'b1;
						r.int_value = acc;
					end
				end
			endcase
			r.prop_id = cur_id;
			r.prop_kind = cur_kind;
			sec_left = sec_left - 28'd1;
			if (done) begin
				r.prop_last = 1'b1;
				if (sec_left == '0) begin
					r.section_last = 1'b1;
					ph = PH_OUTSIDE;
				end else begin
					ph = PH_ID;
				end
			end else if (sec_left == '0) begin
				// Section count ran out inside a property: flag overrun and leave.
				r.prop_last = 1'b1;
				r.section_last = 1'b1;
				r.error_code = ERR_OVERRUN;
				ph = PH_OUTSIDE;
			end
		end
		return r;
	endfunction

	// Offer one request, hold it until accepted, then record its expected tag.
	// Call at a rising edge; returns at the rising edge of acceptance or after a gap.
	task automatic send_byte(input logic [7:0] b, input logic s);
		result_t r;
		in_valid <= 1'b1;
		data_byte <= b;
		section_start <= s;
		driving = 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		if (s) begin
			sections_opened++;
			if (ph != PH_OUTSIDE)
				restarts++;
		end
		r = tag_byte(b, s);
		tag_queue.insert(tag_queue.size(), r);
		bytes_sent++;
		if (r.prop_last)
			props_closed++;
		if (r.error_code == ERR_UNKNOWN)
			unknown_seen++;
		if (r.error_code == ERR_OVERRUN)
			overruns_seen++;
		if (r.byte_role == ROLE_OUTSIDE)
			stray_seen++;
		// End of burst: drop valid in this same step, then idle a random gap.
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			driving = 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 20);
		end else begin
			burst_left--;
		end
	endtask

	// Hold the sender off until every predicted tag has come back.
	task automatic drain_results();
		if (driving)
			in_valid <= 1'b0;
		driving = 1'b0;
		do @(posedge clk); while (tag_queue.size() != 0);
	endtask

	// Encode a section length, sometimes padded with redundant groups up to the limit.
	task automatic send_length(input int unsigned len);
		int nb;
		int g;
		logic [7:0] b;
		nb = 1;
		while (nb < VARINT_MAX && (len >> (7 * nb)) != 0)
			nb++;
		if ($urandom_range(0, 5) == 0)
			nb = $urandom_range(nb, VARINT_MAX);
		for (g = 0; g < nb; g++) begin
			b = 8'((len >> (7 * g)) & 32'h7F);
			if (g < nb - 1)
				b[7] = 1'b1;
			else if (nb == VARINT_MAX)
				b[7] = 1'($urandom_range(0, 1));
			send_byte(b, g == 0);
		end
	endtask

	task automatic send_body(input int count);
		int i;
		for (i = 0; i < count; i++)
			send_byte(section_body[i], 1'b0);
	endtask

	task automatic add_random_bytes(input int count);
		logic [7:0] b;
		repeat (count) begin
			b = 8'($urandom);
			// Bias toward the extremes now and then.
			if ($urandom_range(0, 7) == 0)
				b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			section_body.insert(section_body.size(), b);
		end
	endtask

	// Append one length-prefixed string; mostly short, a few longer.
	task automatic add_prefixed();
		logic [15:0] len;
		len = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(7, 40))
			: 16'($urandom_range(0, 6));
		section_body.insert(section_body.size(), len[15:8]);
		section_body.insert(section_body.size(), len[7:0]);
		add_random_bytes(int'(len));
	endtask

	// Append a well-formed property with random content for the given identifier.
	task automatic add_property(input logic [7:0] id);
		int n;
		int g;
		logic [7:0] b;
		section_body.insert(section_body.size(), id);
		case (id_kind(id)) inside
			K_BYTE: add_random_bytes(1);
			K_TWO: add_random_bytes(2);
			K_FOUR: add_random_bytes(4);
			K_VARINT: begin
				n = $urandom_range(1, VARINT_MAX);
				for (g = 0; g < n; g++) begin
					b = 8'($urandom);
					if (g < n - 1)
						b[7] = 1'b1;
					else if (n < VARINT_MAX)
						b[7] = 1'b0;
					section_body.insert(section_body.size(), b);
				end
			end
			K_STRING, K_BINARY: add_prefixed();
			K_PAIR: begin
				add_prefixed();
				add_prefixed();
			end
			default: ;
		endcase
	endtask

	task automatic build_body(input int nprops);
		logic [7:0] id;
		section_body = {};
		repeat (nprops) begin
			if ($urandom_range(0, 7) == 0) begin
				do id = 8'($urandom); while (id_kind(id) != K_UNKNOWN);
			end else begin
				do id = 8'($urandom); while (id_kind(id) == K_UNKNOWN);
			end
			add_property(id);
		end
	endtask

	task automatic test_stray_bytes();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
	endtask

	// Zero length in one group, then in four groups ending on a set continuation bit.
	task automatic test_empty_sections();
		send_byte(8'h00, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
	endtask

	// One section holding every value form, an empty string, an empty first pair
	// string, a four-group varint, and an unknown identifier as the last byte.
	task automatic test_each_kind();
		section_body = {8'h01, 8'hFF,
			8'h13, 8'hA5, 8'h5A,
			8'h02, 8'h80, 8'h00, 8'h00, 8'h01,
			8'h0B, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h03, 8'h00, 8'h00,
			8'h09, 8'h00, 8'h02, 8'hC3, 8'h3C,
			8'h26, 8'h00, 8'h00, 8'h00, 8'h01, 8'h7E,
			8'h00};
		send_byte(8'(section_body.size()), 1'b1);
		send_body(section_body.size());
	endtask

	// Overrun inside a fixed value, a stray after it, the largest section length,
	// a maximal string prefix, then a restart that abandons that section.
	task automatic test_overrun_and_restart();
		send_byte(8'h03, 1'b1);
		send_byte(8'h02, 1'b0);
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(8'h33, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h26, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h02, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h7F, 1'b0);
	endtask

	// Mostly well-formed sections with random content; the rest are cut short,
	// abandoned by a restart, or plain noise.
	task automatic test_random_sections();
		int goal;
		int plan;
		int size;
		int i;
		bit paused;
		goal = bytes_sent + RANDOM_BYTES;
		paused = 1'b0;
		while (bytes_sent < goal) begin
			if (!paused && bytes_sent >= goal - RANDOM_BYTES / 2) begin
				drain_results();
				paused = 1'b1;
			end
			plan = $urandom_range(0, 9);
			build_body($urandom_range(0, 6));
			size = section_body.size();
			if (plan <= 6 || size == 0) begin
				send_length(size);
				send_body(size);
			end else if (plan == 7) begin
				// Declare fewer bytes than the body holds; leftovers land outside.
				send_length((size > 1) ? $urandom_range(1, size - 1) : 1);
				send_body(size);
			end else if (plan == 8) begin
				if ($urandom_range(0, 3) == 0)
					send_byte(8'h80 | 8'($urandom), 1'b1);
				send_length(size);
				send_body($urandom_range(0, size - 1));
				send_byte(8'($urandom), 1'b1);
				send_byte(8'h00, 1'b0);
			end else begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0);
				send_length($urandom_range(1, 24));
				for (i = $urandom_range(0, 24); i > 0; i--)
					send_byte(8'($urandom), 1'b0);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("result %0d: %s expected 0x%0h, got 0x%0h",
					results_checked, name, exp_v, act_v);
		end
	endtask

	// Receiver: switch stall mode every so often, including stretches of full rate.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(RX_ALWAYS, RX_PATTERN);
			rx_left = $urandom_range(16, 200);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_ALWAYS: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default: begin
				out_ready <= rx_pattern[0];
				rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
			end
		endcase
	end

	// Compare every accepted result with the oldest expected tag.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			got = {byte_role, data_out, prop_id, prop_kind, int_value,
				prop_last, section_last, error_code};
			if (tag_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result %0d: unexpected, data_out 0x%0h role %0d",
						results_checked, data_out, byte_role);
			end else begin
				want = tag_queue.pop_front();
				check_field("byte_role", 32'(want.byte_role), 32'(got.byte_role));
				check_field("data_out", 32'(want.data_out), 32'(got.data_out));
				check_field("prop_id", 32'(want.prop_id), 32'(got.prop_id));
				check_field("prop_kind", 32'(want.prop_kind), 32'(got.prop_kind));
				check_field("int_value", want.int_value, got.int_value);
				check_field("prop_last", 32'(want.prop_last), 32'(got.prop_last));
				check_field("section_last", 32'(want.section_last),
					32'(got.section_last));
				check_field("error_code", 32'(want.error_code), 32'(got.error_code));
			end
			results_checked++;
		end
	end

	// Watchdog: end the run if the stream stalls for good.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d tags still pending",
				cycle_count, tag_queue.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_stray_bytes();
		test_empty_sections();
		test_each_kind();
		test_overrun_and_restart();
		drain_results();
		test_random_sections();
		drain_results();
		repeat (SETTLE_WAIT) @(posedge clk);
		$display("covered %0d bytes in %0d sections (%0d restarts, %0d stray bytes)",
			bytes_sent, sections_opened, restarts, stray_seen);
		$display("closed %0d properties: %0d unknown ids, %0d overruns; %0d results checked",
			props_closed, unknown_seen, overruns_seen, results_checked);
		if (mismatches == 0 && tag_queue.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
